/* hdl/page_frame_replacement_unit_macros.svh */
// Assertion macros shared by the page frame replacement unit modules.
`ifndef PAGE_FRAME_REPLACEMENT_UNIT_MACROS_SVH
`define PAGE_FRAME_REPLACEMENT_UNIT_MACROS_SVH

// Property holds on every clock edge out of reset.
`define PFR_ASSERT_ALWAYS(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("pfr: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define PFR_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("pfr: same-cycle implication failed");

// Consequent holds in the cycle after the antecedent.
`define PFR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("pfr: next-cycle implication failed");

`endif

/* hdl/pfr_pkg.sv */
// Shared types and constants for the page frame replacement unit.
`default_nettype none

package pfr_pkg;

    localparam int PID_BITS           = 7;
    localparam int PAGE_BITS          = 5;
    localparam int TAG_BITS           = PID_BITS + PAGE_BITS;
    localparam int FRAME_IDX_BITS     = 3;
    localparam int SLOT_IDX_BITS      = 4;
    localparam int FRAMES_DEFAULT     = 8;
    localparam int SWAP_SLOTS_DEFAULT = 16;
    localparam int CFG_ADDR_BITS      = 3;
    localparam int CFG_DATA_BITS      = 32;

    // Register word indexes (byte address / 4)
    localparam logic [CFG_ADDR_BITS-3:0] REG_POLICY_MODE = '0;

    typedef enum logic {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } policy_t;

    typedef enum logic [1:0] {
        OUT_HIT      = 2'd0,
        OUT_FILL     = 2'd1,
        OUT_PUSH     = 2'd2,
        OUT_EXCHANGE = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_FRAME,
        ST_SCAN_SWAP,
        ST_DRAIN,
        ST_DECIDE,
        ST_VICTIM_RD,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [PID_BITS-1:0]  process_id;
        logic [PAGE_BITS-1:0] page_number;
    } access_t;

    typedef struct packed {
        outcome_t                  outcome;
        logic [FRAME_IDX_BITS-1:0] frame_index;
        logic                      victim_valid;
        logic [PID_BITS-1:0]       victim_process;
        logic [PAGE_BITS-1:0]      victim_page;
        logic [SLOT_IDX_BITS-1:0]  swap_slot;
    } result_t;

    // Which tag store the compare unit looks at this cycle
    typedef struct packed {
        logic frame_en;
        logic swap_en;
    } scan_ctl_t;

    // What the scan has found so far
    typedef struct packed {
        logic frame_hit;
        logic swap_hit;
        logic free_found;
    } match_flags_t;

endpackage

`default_nettype wire

/* hdl/pfr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/pfr_rank.sv */
// Recency rank table: exact age per frame, 0 = most recently used.
`default_nettype none
`include "page_frame_replacement_unit_macros.svh"

module pfr_rank #(
    parameter int FRAMES = pfr_pkg::FRAMES_DEFAULT,
    localparam int FW = $clog2(FRAMES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          touch_en,
    input  logic [FW-1:0] touch_idx,
    input  logic [FW-1:0] rd_idx,
    output logic          rd_oldest
);

    logic [FW-1:0]     rank_reg  [FRAMES];
    logic [FW-1:0]     rank_next [FRAMES];
    logic [FW-1:0]     old_rank;
    logic [FRAMES-1:0] mru_vec;
    logic [FRAMES-1:0] oldest_vec;

    // Touch: the frame becomes age 0, younger frames age by one
    always_comb
    begin
        old_rank = rank_reg[touch_idx];
        for (int i = 0; i < FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (touch_en)
            begin
                if (FW'(i) == touch_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (rank_reg[i] < old_rank)
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                rank_reg[i] <= FW'(FRAMES - 1 - i);
            end
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    // Oldest frame test at the scan position
    assign rd_oldest = (rank_reg[rd_idx] == FW'(FRAMES - 1));

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            mru_vec[i]    = (rank_reg[i] == '0);
            oldest_vec[i] = (rank_reg[i] == FW'(FRAMES - 1));
        end
    end

    // Ranks stay a permutation: exactly one youngest and one oldest frame
    `PFR_ASSERT_ALWAYS(a_one_mru, clk, rst_n, $onehot(mru_vec))
    `PFR_ASSERT_ALWAYS(a_one_oldest, clk, rst_n, $onehot(oldest_vec))

endmodule

`default_nettype wire

/* hdl/pfr_match.sv */
// Shared tag comparator with first-match trackers for frames and swap slots.
`default_nettype none

module pfr_match #(
    parameter int FRAMES     = pfr_pkg::FRAMES_DEFAULT,
    parameter int SWAP_SLOTS = pfr_pkg::SWAP_SLOTS_DEFAULT,
    localparam int FW = $clog2(FRAMES),
    localparam int SW = $clog2(SWAP_SLOTS),
    localparam int IW = (FW > SW) ? FW : SW
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  pfr_pkg::scan_ctl_t            ctl,
    input  logic [IW-1:0]                 entry_idx,
    input  logic                          entry_valid,
    input  logic [pfr_pkg::TAG_BITS-1:0]  entry_tag,
    input  logic [pfr_pkg::TAG_BITS-1:0]  key,
    input  logic                          entry_oldest,
    output pfr_pkg::match_flags_t         flags,
    output logic [FW-1:0]                 hit_frame,
    output logic [FW-1:0]                 free_frame,
    output logic [FW-1:0]                 lru_frame,
    output logic [SW-1:0]                 hit_slot
);

    import pfr_pkg::*;

    match_flags_t  flags_reg, flags_next;
    logic [FW-1:0] hit_frame_reg, hit_frame_next;
    logic [FW-1:0] free_frame_reg, free_frame_next;
    logic [FW-1:0] lru_frame_reg, lru_frame_next;
    logic [SW-1:0] hit_slot_reg, hit_slot_next;
    logic          tag_eq;

    // The one comparator, used for every stored tag in turn
    assign tag_eq = entry_valid && (entry_tag == key);

    // Keep the lowest matching index of each kind, and the oldest frame's index
    always_comb
    begin
        flags_next      = flags_reg;
        hit_frame_next  = hit_frame_reg;
        free_frame_next = free_frame_reg;
        lru_frame_next  = lru_frame_reg;
        hit_slot_next   = hit_slot_reg;
        if (clear)
        begin
            flags_next = '0;
        end
        else
        begin
            if (ctl.frame_en)
            begin
                if (tag_eq && !flags_reg.frame_hit)
                begin
                    flags_next.frame_hit = 1'b1;
                    hit_frame_next       = entry_idx[FW-1:0];
                end
                if (!entry_valid && !flags_reg.free_found)
                begin
                    flags_next.free_found = 1'b1;
                    free_frame_next       = entry_idx[FW-1:0];
                end
                if (entry_oldest)
                begin
                    lru_frame_next = entry_idx[FW-1:0];
                end
            end
            if (ctl.swap_en)
            begin
                if (tag_eq && !flags_reg.swap_hit)
                begin
                    flags_next.swap_hit = 1'b1;
                    hit_slot_next       = entry_idx[SW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_frame_reg  <= hit_frame_next;
        free_frame_reg <= free_frame_next;
        lru_frame_reg  <= lru_frame_next;
        hit_slot_reg   <= hit_slot_next;
    end

    assign flags      = flags_reg;
    assign hit_frame  = hit_frame_reg;
    assign free_frame = free_frame_reg;
    assign lru_frame  = lru_frame_reg;
    assign hit_slot   = hit_slot_reg;

endmodule

`default_nettype wire

/* hdl/page_frame_replacement_unit.sv */
// Page frame replacement unit: FIFO or LRU victim choice over frames and a swap ring.
//
// Usage:
//   access channel (access_valid/access_ready, payload access) takes one page
//   access (process id, page number). result channel (result_valid/
//   result_ready, payload result) returns exactly one result per access.
//   The APB port holds policy_mode at byte address 0 (0 FIFO, 1 LRU); write
//   it only while the unit is idle. pready is tied high.
// Sequencing:
//   each access is handled by one shared tag comparator that walks all frame
//   tags, then all swap tags, one per cycle out of the tag RAMs, then passes
//   through the drain, decide, victim read and update states; the result is
//   registered at the update. The next access is taken only after that
//   commit: access_ready is high only between accesses.
// Reset:
//   all frames and swap slots empty, both pointers 0, frame i has age
//   FRAMES-1-i, policy FIFO. No clearing pass; valid bits reset at once.
// Back pressure:
//   a result waits in the output register; the next access is still taken
//   and scanned, and its state update holds until the output register frees.
`default_nettype none
`include "page_frame_replacement_unit_macros.svh"

module page_frame_replacement_unit #(
    parameter int FRAMES     = pfr_pkg::FRAMES_DEFAULT,
    parameter int SWAP_SLOTS = pfr_pkg::SWAP_SLOTS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pfr_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [pfr_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [pfr_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    // Access channel
    input  logic                               access_valid,
    output logic                               access_ready,
    input  pfr_pkg::access_t                   access,
    // Result channel
    output logic                               result_valid,
    input  logic                               result_ready,
    output pfr_pkg::result_t                   result
);

    import pfr_pkg::*;

    localparam int FW = $clog2(FRAMES);
    localparam int SW = $clog2(SWAP_SLOTS);
    localparam int IW = (FW > SW) ? FW : SW;

    state_t                  state_reg, state_next;
    logic [IW-1:0]           cnt_reg, cnt_next;
    scan_ctl_t               scan_reg, scan_next;
    logic [IW-1:0]           scan_idx_reg, scan_idx_next;
    logic [TAG_BITS-1:0]     key_reg, key_next;
    logic [FW-1:0]           frame_reg, frame_next;
    outcome_t                outcome_reg, outcome_next;
    logic [FW-1:0]           fifo_ptr_reg, fifo_ptr_next;
    logic [SW-1:0]           swap_ptr_reg, swap_ptr_next;
    logic [FRAMES-1:0]       frame_valid_reg, frame_valid_next;
    logic [SWAP_SLOTS-1:0]   swap_valid_reg, swap_valid_next;
    policy_t                 policy_reg, policy_next;
    logic                    result_valid_reg, result_valid_next;
    result_t                 result_reg, result_next;

    logic                    cfg_wr;
    logic [CFG_ADDR_BITS-3:0] cfg_idx;
    logic                    match_clear;
    logic                    update_fire;
    logic                    victim;
    logic [FW-1:0]           frame_raddr;
    logic [SW-1:0]           swap_raddr;
    logic [SW-1:0]           swap_waddr;
    logic                    frame_we;
    logic                    swap_we;
    logic [TAG_BITS-1:0]     frame_rdata;
    logic [TAG_BITS-1:0]     swap_rdata;
    logic                    entry_valid;
    logic [TAG_BITS-1:0]     entry_tag;
    logic                    entry_oldest;
    match_flags_t            match_flags;
    logic [FW-1:0]           hit_frame;
    logic [FW-1:0]           free_frame;
    logic [FW-1:0]           lru_frame;
    logic [SW-1:0]           hit_slot;

    // Configuration register
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_ADDR_BITS-1:2];
    assign policy_next = (cfg_wr && (cfg_idx == REG_POLICY_MODE)) ?
                         policy_t'(pwdata[0]) : policy_reg;
    assign prdata = (cfg_idx == REG_POLICY_MODE) ?
                    {{(CFG_DATA_BITS-1){1'b0}}, policy_reg} : '0;

    // Tag stores
    pfr_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (FRAMES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_reg),
        .wdata (key_reg),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    pfr_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (SWAP_SLOTS)
    ) u_swap_ram (
        .clk   (clk),
        .we    (swap_we),
        .waddr (swap_waddr),
        .wdata (frame_rdata),
        .raddr (swap_raddr),
        .rdata (swap_rdata)
    );

    // Entry presented to the comparator in the cycle after its RAM address
    assign entry_valid = scan_reg.frame_en ? frame_valid_reg[scan_idx_reg[FW-1:0]]
                                           : swap_valid_reg[scan_idx_reg[SW-1:0]];
    assign entry_tag   = scan_reg.frame_en ? frame_rdata : swap_rdata;

    pfr_rank #(
        .FRAMES (FRAMES)
    ) u_rank (
        .clk       (clk),
        .rst_n     (rst_n),
        .touch_en  (update_fire),
        .touch_idx (frame_reg),
        .rd_idx    (scan_idx_reg[FW-1:0]),
        .rd_oldest (entry_oldest)
    );

    pfr_match #(
        .FRAMES     (FRAMES),
        .SWAP_SLOTS (SWAP_SLOTS)
    ) u_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (match_clear),
        .ctl          (scan_reg),
        .entry_idx    (scan_idx_reg),
        .entry_valid  (entry_valid),
        .entry_tag    (entry_tag),
        .key          (key_reg),
        .entry_oldest (entry_oldest),
        .flags        (match_flags),
        .hit_frame    (hit_frame),
        .free_frame   (free_frame),
        .lru_frame    (lru_frame),
        .hit_slot     (hit_slot)
    );

    assign victim = (outcome_reg == OUT_PUSH) || (outcome_reg == OUT_EXCHANGE);

    // Sequencer and state update
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        scan_next         = '0;
        scan_idx_next     = cnt_reg;
        key_next          = key_reg;
        frame_next        = frame_reg;
        outcome_next      = outcome_reg;
        fifo_ptr_next     = fifo_ptr_reg;
        swap_ptr_next     = swap_ptr_reg;
        frame_valid_next  = frame_valid_reg;
        swap_valid_next   = swap_valid_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        match_clear       = 1'b0;
        update_fire       = 1'b0;
        access_ready      = 1'b0;
        frame_raddr       = frame_reg;
        swap_raddr        = cnt_reg[SW-1:0];
        frame_we          = 1'b0;
        swap_we           = 1'b0;
        swap_waddr        = (outcome_reg == OUT_EXCHANGE) ? hit_slot : swap_ptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                access_ready = 1'b1;
                if (access_valid)
                begin
                    key_next    = {access.process_id, access.page_number};
                    cnt_next    = '0;
                    match_clear = 1'b1;
                    state_next  = ST_SCAN_FRAME;
                end
            end
            ST_SCAN_FRAME:
            begin
                frame_raddr        = cnt_reg[FW-1:0];
                scan_next.frame_en = 1'b1;
                if (cnt_reg == IW'(FRAMES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN_SWAP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN_SWAP:
            begin
                scan_next.swap_en = 1'b1;
                if (cnt_reg == IW'(SWAP_SLOTS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (match_flags.frame_hit)
                begin
                    frame_next   = hit_frame;
                    outcome_next = OUT_HIT;
                end
                else if (match_flags.free_found)
                begin
                    frame_next   = free_frame;
                    outcome_next = OUT_FILL;
                end
                else
                begin
                    frame_next   = (policy_reg == POLICY_LRU) ? lru_frame : fifo_ptr_reg;
                    outcome_next = match_flags.swap_hit ? OUT_EXCHANGE : OUT_PUSH;
                end
                state_next = ST_VICTIM_RD;
            end
            ST_VICTIM_RD:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    update_fire = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Commit the access: tag writes, pointers, result
        if (update_fire)
        begin
            if (outcome_reg != OUT_HIT)
            begin
                frame_we                    = 1'b1;
                frame_valid_next[frame_reg] = 1'b1;
                if (policy_reg == POLICY_FIFO)
                begin
                    fifo_ptr_next = (frame_reg == FW'(FRAMES - 1)) ? '0 : frame_reg + 1'b1;
                end
            end
            if (victim)
            begin
                swap_we                     = 1'b1;
                swap_valid_next[swap_waddr] = 1'b1;
            end
            if (outcome_reg == OUT_PUSH)
            begin
                swap_ptr_next = (swap_ptr_reg == SW'(SWAP_SLOTS - 1)) ? '0
                                                                      : swap_ptr_reg + 1'b1;
            end
            result_next.outcome        = outcome_reg;
            result_next.frame_index    = FRAME_IDX_BITS'(frame_reg);
            result_next.victim_valid   = victim;
            result_next.victim_process = victim ? frame_rdata[TAG_BITS-1 -: PID_BITS] : '0;
            result_next.victim_page    = victim ? frame_rdata[PAGE_BITS-1:0] : '0;
            result_next.swap_slot      = victim ? SLOT_IDX_BITS'(swap_waddr) : '0;
            result_valid_next          = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            scan_reg         <= '0;
            fifo_ptr_reg     <= '0;
            swap_ptr_reg     <= '0;
            frame_valid_reg  <= '0;
            swap_valid_reg   <= '0;
            policy_reg       <= POLICY_FIFO;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            scan_reg         <= scan_next;
            fifo_ptr_reg     <= fifo_ptr_next;
            swap_ptr_reg     <= swap_ptr_next;
            frame_valid_reg  <= frame_valid_next;
            swap_valid_reg   <= swap_valid_next;
            policy_reg       <= policy_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        key_reg      <= key_next;
        frame_reg    <= frame_next;
        outcome_reg  <= outcome_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // An eviction only happens when every frame is occupied
    `PFR_ASSERT_IMPLIES(a_victim_needs_full, clk, rst_n, update_fire && victim, &frame_valid_reg)
    // An exchange needs a swap hit and no frame hit
    `PFR_ASSERT_IMPLIES(a_exchange_has_slot, clk, rst_n, update_fire && (outcome_reg == OUT_EXCHANGE), match_flags.swap_hit && !match_flags.frame_hit)
    // A commit shows its outcome in the output register the next cycle
    `PFR_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, update_fire, result_valid && (result.outcome == $past(outcome_reg)))

endmodule

`default_nettype wire

/* bench/page_frame_replacement_unit_tb.sv */
// Self-checking testbench for the page frame replacement unit.
`default_nettype none

module page_frame_replacement_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfr_pkg::*;

    localparam int NFRAMES    = FRAMES_DEFAULT;
    localparam int NSLOTS     = SWAP_SLOTS_DEFAULT;
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 150;
    localparam int POOL_SIZE  = 20;
    localparam int DRAIN_WAIT = 40;   // settle time after the last expected result
    localparam int HOLD_LEN   = 400;

    // Tracks frame/swap occupancy and holds the results each access must produce
    class page_placement_board;
        logic                 frame_used [NFRAMES];
        logic [PID_BITS-1:0]  frame_pid  [NFRAMES];
        logic [PAGE_BITS-1:0] frame_page [NFRAMES];
        logic [2:0]           frame_age  [NFRAMES];
        logic                 slot_used  [NSLOTS];
        logic [PID_BITS-1:0]  slot_pid   [NSLOTS];
        logic [PAGE_BITS-1:0] slot_page  [NSLOTS];
        logic [2:0]           fifo_ptr;
        logic [3:0]           ring_ptr;
        policy_t              policy;
        result_t              expected_results [$];
        int                   errors;

        function new();
            for (int i = 0; i < NFRAMES; i++)
            begin
                frame_used[i] = 1'b0;
                frame_pid[i]  = '0;
                frame_page[i] = '0;
                frame_age[i]  = 3'(NFRAMES - 1 - i);
            end
            for (int i = 0; i < NSLOTS; i++)
            begin
                slot_used[i] = 1'b0;
                slot_pid[i]  = '0;
                slot_page[i] = '0;
            end
            fifo_ptr = '0;
            ring_ptr = '0;
            policy   = POLICY_FIFO;
            errors   = 0;
        endfunction

        function void set_policy(policy_t p);
            policy = p;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Work out placement, eviction and recency for one access
        function result_t predict_placement(access_t a);
            int      hit;
            int      in_swap;
            int      free_f;
            int      f;
            int      slot;
            logic [2:0] old_age;
            result_t r;
            hit     = -1;
            in_swap = -1;
            free_f  = -1;
            slot    = 0;
            r       = '0;
            for (int i = 0; i < NFRAMES; i++)
            begin
                if (hit < 0 && frame_used[i] && frame_pid[i] == a.process_id &&
                    frame_page[i] == a.page_number)
                    hit = i;
                if (free_f < 0 && !frame_used[i])
                    free_f = i;
            end
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (in_swap < 0 && slot_used[i] && slot_pid[i] == a.process_id &&
                    slot_page[i] == a.page_number)
                    in_swap = i;
            end

            if (hit >= 0)
            begin
                f = hit;
                r.outcome = OUT_HIT;
            end
            else if (free_f >= 0)
            begin
                f = free_f;
                r.outcome = OUT_FILL;
            end
            else
            begin
                // Victim: oldest frame in LRU mode, FIFO pointer otherwise
                if (policy == POLICY_LRU)
                begin
                    f = 0;
                    for (int i = 1; i < NFRAMES; i++)
                        if (frame_age[i] > frame_age[f])
                            f = i;
                end
                else
                    f = fifo_ptr;
                r.victim_valid   = 1'b1;
                r.victim_process = frame_pid[f];
                r.victim_page    = frame_page[f];
                if (in_swap >= 0)
                begin
                    slot = in_swap;
                    r.outcome = OUT_EXCHANGE;
                end
                else
                begin
                    slot = ring_ptr;
                    ring_ptr = ring_ptr + 4'd1;
                    r.outcome = OUT_PUSH;
                end
                slot_used[slot] = 1'b1;
                slot_pid[slot]  = frame_pid[f];
                slot_page[slot] = frame_page[f];
            end

            if (r.outcome != OUT_HIT)
            begin
                frame_used[f] = 1'b1;
                frame_pid[f]  = a.process_id;
                frame_page[f] = a.page_number;
                if (policy == POLICY_FIFO)
                    fifo_ptr = 3'(f + 1);
            end

            // Touched frame becomes youngest, younger ones age by one
            old_age = frame_age[f];
            for (int i = 0; i < NFRAMES; i++)
                if (frame_age[i] < old_age)
                    frame_age[i] = frame_age[i] + 3'd1;
            frame_age[f] = '0;

            r.frame_index = 3'(f);
            r.swap_slot   = 4'(slot);
            return r;
        endfunction

        function void note_access(access_t a);
            expected_results.push_back(predict_placement(a));
        endfunction

        function void report(string field, int unsigned exp_v, int unsigned act_v);
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field,
                     exp_v, act_v);
            errors++;
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: unexpected result transaction, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (got.outcome !== exp_r.outcome)
                report("outcome", exp_r.outcome, got.outcome);
            if (got.frame_index !== exp_r.frame_index)
                report("frame_index", exp_r.frame_index, got.frame_index);
            if (got.victim_valid !== exp_r.victim_valid)
                report("victim_valid", exp_r.victim_valid, got.victim_valid);
            if (got.victim_process !== exp_r.victim_process)
                report("victim_process", exp_r.victim_process, got.victim_process);
            if (got.victim_page !== exp_r.victim_page)
                report("victim_page", exp_r.victim_page, got.victim_page);
            if (got.swap_slot !== exp_r.swap_slot)
                report("swap_slot", exp_r.swap_slot, got.swap_slot);
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     access_valid = 1'b0;
    logic                     access_ready;
    access_t                  access = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    result_t                  result;

    page_placement_board      board;
    access_t                  tag_pool [POOL_SIZE];
    bit                       steady = 1'b0;
    int                       hold_left = 0;
    int                       cfg_errors = 0;

    page_frame_replacement_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .access_valid (access_valid),
        .access_ready (access_ready),
        .access       (access),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check accepted transactions, idle at random, honor hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                board.check_result(result);
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
                result_ready <= steady || ($urandom_range(0, 99) >= 21);
        end
    end

    // Policy register write, then read back; called at a clock edge
    task automatic set_policy_reg(policy_t p);
        logic [CFG_DATA_BITS-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_POLICY_MODE, 2'b00};
        pwdata  <= CFG_DATA_BITS'(p);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.set_policy(p);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[0] !== p)
        begin
            $display("%0t ns: policy_mode readback mismatch, expected %0d, actual %0d",
                     $time, p, rd[0]);
            cfg_errors++;
        end
    endtask

    // Offer one access transaction, with an optional random gap first
    task automatic send_access(logic [PID_BITS-1:0] pid, logic [PAGE_BITS-1:0] page);
        access_t a;
        a.process_id  = pid;
        a.page_number = page;
        if (!steady && $urandom_range(0, 99) < 21)
        begin
            access_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        access_valid <= 1'b1;
        access       <= a;
        do @(posedge clk); while (access_ready !== 1'b1);
        board.note_access(a);
    endtask

    // Drop valid and let the unit go quiet before touching configuration
    task automatic drain();
        access_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Small working set so hits, swap exchanges and ring pushes all recur
    task automatic refill_pool();
        logic [PID_BITS-1:0] pids [3];
        for (int i = 0; i < 3; i++)
            pids[i] = PID_BITS'($urandom_range(0, 127));
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            tag_pool[i].process_id  = pids[$urandom_range(0, 2)];
            tag_pool[i].page_number = ($urandom_range(0, 99) < 85) ?
                                      PAGE_BITS'($urandom_range(1, 16)) :
                                      PAGE_BITS'($urandom_range(0, 31));
        end
    endtask

    initial
    begin
        access_t a;
        policy_t phase_policy [PHASES];
        phase_policy = '{POLICY_FIFO, POLICY_LRU, POLICY_LRU, POLICY_FIFO,
                         POLICY_LRU, POLICY_FIFO};
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_policy_reg(POLICY_FIFO);

        // Directed, FIFO: odd tags, fills, a hit, then pushes and exchanges
        send_access(7'd0, 5'd0);
        send_access(7'd127, 5'd31);
        send_access(7'd127, 5'd31);
        for (int p = 1; p <= 6; p++)
            send_access(7'd1, 5'(p));
        send_access(7'd1, 5'd7);
        send_access(7'd0, 5'd0);
        send_access(7'd127, 5'd31);
        send_access(7'd85, 5'd10);
        send_access(7'd42, 5'd21);
        drain();

        // Directed, LRU: refresh a few frames so the oldest is not the FIFO one
        set_policy_reg(POLICY_LRU);
        send_access(7'd1, 5'd3);
        send_access(7'd1, 5'd4);
        send_access(7'd0, 5'd0);
        send_access(7'd3, 5'd3);
        send_access(7'd3, 5'd3);
        send_access(7'd1, 5'd7);
        send_access(7'd85, 5'd10);
        send_access(7'd127, 5'd16);
        drain();

        // Random phases across both policies
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_policy_reg(phase_policy[ph]);
            steady = (ph == 2);
            refill_pool();
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (ph == 4 && n == 10)
                    hold_left = HOLD_LEN;
                if ($urandom_range(0, 99) < 80)
                    a = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                begin
                    a.process_id  = PID_BITS'($urandom_range(0, 127));
                    a.page_number = PAGE_BITS'($urandom_range(0, 31));
                end
                send_access(a.process_id, a.page_number);
            end
            drain();
            steady = 1'b0;
        end

        if (board.errors == 0 && cfg_errors == 0 && board.pending() == 0)
            $display("page_frame_replacement_unit regression: pass");
        else
            $display("page_frame_replacement_unit regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("page_frame_replacement_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
